FILE: rtl/plmw_pkg.sv
package plmw_pkg;

	localparam int POSITION_FRAC_BITS = 4;
	localparam int EXP_TABLE_DEPTH    = 256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_OFFSET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SCORE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PROB      = 2'd3;

	localparam logic signed [8:0] RST_SCORE_OFFSET  = -9'sd64;
	localparam logic [15:0]       RST_DISTANCE_GAIN = 16'd66;
	localparam logic [15:0]       RST_MAX_SCORE     = 16'd5000;
	localparam logic [15:0]       RST_MIN_PROB      = 16'd655;

	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	localparam logic [20:0] LOG2E_Q20 = 21'd1512775;
	localparam logic [63:0] DEG_Q30   = 64'd18740330;

	localparam logic signed [39:0] SUM_LIMIT = 40'sh7F_FFFF_FFFF;

	localparam int COS_DEPTH       = 91;
	localparam int EXP_SHIFT_LIMIT = 47;

	function automatic logic [31:0] exp2_entry(input logic [63:0] y);
		logic signed [63:0] sum;
		logic [63:0]        term;
		logic [63:0]        res;
		sum  = 64'sd1 <<< 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * y) >> 32) / 64'(k);
			if (k % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		res = ($unsigned(sum) + 64'd2) >> 2;
		return res[31:0];
	endfunction

	function automatic logic [16:0] cos_entry(input int i);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic signed [63:0] sum;
		logic [63:0]        term;
		logic [63:0]        res;
		x    = 64'(i) * DEG_Q30;
		x2   = (x * x) >> 30;
		sum  = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = 64'sd0;
		end
		res = ($unsigned(sum) + 64'd8192) >> 14;
		return res[16:0];
	endfunction

endpackage

FILE: rtl/particle_line_match_weight_top.sv
// channel   dir  signals                     contents
// s_axis    in   tvalid tready tdata tlast   one sample point, tlast ends the particle
// m_axis    out  tvalid tready tdata tuser   weight and clamped score of one particle
// cfg       in   cfg_we cfg_addr cfg_wdata   register writes, no read-back
//
// A sample passes the sequencer states from acceptance back to ready, paced by the one
// shared 33x33 multiplier; a new sample waits until it is done. A last sample adds
// 16 log2 squarings, one product, a 21-step restoring divider and the exp table read.
// arst_n clears the sequencer, score sum and output valid and sets registers to defaults.
// The result sits in an output register; the block stalls only if a new result
// is ready while the previous one is still not taken.
module particle_line_match_weight_top #(
	parameter int POSITION_FRAC_BITS = plmw_pkg::POSITION_FRAC_BITS,
	parameter int EXP_TABLE_DEPTH    = plmw_pkg::EXP_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [plmw_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [plmw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// offset_x[12:0] offset_y[25:13] heading_deg[34:26] map_cost[42:35] map_angle[50:43]
	input  logic [55:0]                         s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// particle_weight[16:0] clamped_score[33:17]
	output logic [39:0]                         m_axis_tdata,
	// was_clamped[0]
	output logic                                m_axis_tuser
);

	localparam int IDX_W   = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
	localparam int IDXP_W  = 16 + $clog2(EXP_TABLE_DEPTH + 1);
	localparam int T_SHIFT = 20 + 2 * POSITION_FRAC_BITS;
	localparam int T_W     = 63 - T_SHIFT;
	localparam int N_W     = T_W - 16;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SQX   = 5'd1;
	localparam logic [4:0] ST_SQY   = 5'd2;
	localparam logic [4:0] ST_DG    = 5'd3;
	localparam logic [4:0] ST_LG0   = 5'd4;
	localparam logic [4:0] ST_LG1   = 5'd5;
	localparam logic [4:0] ST_EXPR  = 5'd6;
	localparam logic [4:0] ST_GAIN  = 5'd7;
	localparam logic [4:0] ST_COSM  = 5'd8;
	localparam logic [4:0] ST_TERM  = 5'd9;
	localparam logic [4:0] ST_ACC   = 5'd10;
	localparam logic [4:0] ST_LOGN  = 5'd11;
	localparam logic [4:0] ST_LOGSQ = 5'd12;
	localparam logic [4:0] ST_LMUL  = 5'd13;
	localparam logic [4:0] ST_DIV   = 5'd14;
	localparam logic [4:0] ST_WEXP  = 5'd15;
	localparam logic [4:0] ST_WOUT  = 5'd16;

	logic [4:0] state_q;

	logic signed [8:0] offset_q;
	logic [15:0]       dgain_q;
	logic [15:0]       maxs_q;
	logic [15:0]       minp_q;

	logic signed [12:0] ox_q;
	logic signed [12:0] oy_q;
	logic [8:0]         hd_q;
	logic [7:0]         cost_q;
	logic [7:0]         ang_q;
	logic               last_q;

	logic [25:0]        d2_q;
	logic [41:0]        p1_q;
	logic [41:0]        p2_q;
	logic [T_W-1:0]     t_q;
	logic [31:0]        rom_q;
	logic [16:0]        gain_q;
	logic signed [26:0] inner_q;
	logic signed [18:0] term_q;
	logic signed [39:0] sum_q;

	logic [23:0]        m_q;
	logic signed [24:0] s_q;
	logic               clamp_q;
	logic [31:0]        y_q;
	logic [19:0]        lres_q;
	logic [46:0]        rem_q;
	logic [44:0]        dsh_q;
	logic [20:0]        quot_q;
	logic [4:0]         cnt_q;

	logic        out_valid_q;
	logic [16:0] out_w_q;
	logic [16:0] out_s_q;
	logic        out_c_q;

	logic [31:0] exp_rom [EXP_TABLE_DEPTH];
	logic [16:0] cos_rom [plmw_pkg::COS_DEPTH];

	for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp
		localparam logic [63:0] Y = (64'(g) * plmw_pkg::LN2_Q32) / 64'(EXP_TABLE_DEPTH);
		localparam logic [31:0] V = plmw_pkg::exp2_entry(Y);
		assign exp_rom[g] = V;
	end

	for (genvar g = 0; g < plmw_pkg::COS_DEPTH; g++) begin : g_cos
		localparam logic [16:0] V = plmw_pkg::cos_entry(g);
		assign cos_rom[g] = V;
	end

	function automatic logic [16:0] exp2_eval(input logic [31:0] v, input logic [N_W-1:0] n);
		logic [63:0] acc;
		logic [5:0]  nn;
		if (n >= N_W'(plmw_pkg::EXP_SHIFT_LIMIT)) begin
			return 17'd0;
		end
		nn  = n[5:0];
		acc = {32'd0, v} + (64'd1 << (6'd13 + nn));
		acc = acc >> (6'd14 + nn);
		return acc[16:0];
	endfunction

	logic [IDXP_W-1:0] idx_prod;
	logic [IDX_W-1:0]  exp_idx;

	assign idx_prod = IDXP_W'(t_q[15:0]) * IDXP_W'(EXP_TABLE_DEPTH);
	assign exp_idx  = idx_prod[16 +: IDX_W];

	always_ff @(posedge clk) begin
		rom_q <= exp_rom[exp_idx];
	end

	logic [8:0] hd_mod;
	logic [9:0] dd_raw;
	logic [9:0] dd_mod;
	logic [9:0] dd_half;
	logic [9:0] dd_quad;
	logic [6:0] cos_idx;
	logic [16:0] cos_val;

	always_comb begin
		hd_mod  = (hd_q >= 9'd360) ? hd_q - 9'd360 : hd_q;
		dd_raw  = {1'b0, hd_mod} + 10'd360 - {2'b0, ang_q};
		dd_mod  = (dd_raw >= 10'd360) ? dd_raw - 10'd360 : dd_raw;
		dd_half = (dd_mod > 10'd180) ? 10'd360 - dd_mod : dd_mod;
		dd_quad = (dd_half > 10'd90) ? 10'd180 - dd_half : dd_half;
		cos_idx = dd_quad[6:0];
		cos_val = cos_rom[cos_idx];
	end

	logic [15:0]        max_eff;
	logic [23:0]        m_w;
	logic signed [40:0] sum_ext;
	logic signed [40:0] m_ext;
	logic [15:0]        p_eff;
	logic [3:0]         p_msb;
	logic signed [26:0] ms_w;
	logic [20:0]        lq_w;

	always_comb begin
		max_eff = (maxs_q == 16'd0) ? 16'd1 : maxs_q;
		m_w     = {max_eff, 8'd0};
		sum_ext = 41'(sum_q);
		m_ext   = $signed({17'd0, m_w});
		p_eff   = (minp_q == 16'd0) ? 16'd1 : minp_q;
		p_msb   = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (p_eff[i]) begin
				p_msb = 4'(i);
			end
		end
		ms_w = $signed({3'd0, m_q}) - 27'(s_q);
		lq_w = 21'd1048576 - {1'b0, lres_q};
	end

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;

	always_comb begin
		unique case (state_q)
			ST_SQX: begin
				mul_a = 33'(ox_q);
				mul_b = 33'(ox_q);
			end
			ST_SQY: begin
				mul_a = 33'(oy_q);
				mul_b = 33'(oy_q);
			end
			ST_DG: begin
				mul_a = $signed({7'd0, d2_q});
				mul_b = $signed({17'd0, dgain_q});
			end
			ST_LG0: begin
				mul_a = $signed({12'd0, p1_q[20:0]});
				mul_b = $signed({12'd0, plmw_pkg::LOG2E_Q20});
			end
			ST_LG1: begin
				mul_a = $signed({12'd0, p1_q[41:21]});
				mul_b = $signed({12'd0, plmw_pkg::LOG2E_Q20});
			end
			ST_COSM: begin
				mul_a = $signed({25'd0, cost_q});
				mul_b = $signed({16'd0, cos_val});
			end
			ST_TERM: begin
				mul_a = 33'(inner_q);
				mul_b = $signed({16'd0, gain_q});
			end
			ST_LOGSQ: begin
				mul_a = $signed({1'b0, y_q});
				mul_b = $signed({1'b0, y_q});
			end
			ST_LMUL: begin
				mul_a = $signed({12'd0, lq_w});
				mul_b = $signed({7'd0, ms_w[25:0]});
			end
			default: begin
				mul_a = 33'sd0;
				mul_b = 33'sd0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	logic [62:0]        t_full;
	logic signed [42:0] tsum;
	logic signed [40:0] acc_w;
	logic [31:0]        ysq;
	logic               div_ge;
	logic [20:0]        quot_next;
	logic signed [25:0] rnd_s;

	always_comb begin
		t_full    = {mul_p[41:0], 21'd0} + {21'd0, p2_q};
		tsum      = mul_p[42:0] + 43'sd8388608;
		acc_w     = 41'(sum_q) + 41'(term_q);
		ysq       = mul_p[61:30];
		div_ge    = rem_q >= {2'd0, dsh_q};
		quot_next = {quot_q[19:0], div_ge};
		rnd_s     = 26'(s_q) + 26'sd128;
	end

	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= plmw_pkg::RST_SCORE_OFFSET;
			dgain_q  <= plmw_pkg::RST_DISTANCE_GAIN;
			maxs_q   <= plmw_pkg::RST_MAX_SCORE;
			minp_q   <= plmw_pkg::RST_MIN_PROB;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				plmw_pkg::REG_SCORE_OFFSET:  offset_q <= $signed(cfg_wdata[8:0]);
				plmw_pkg::REG_DISTANCE_GAIN: dgain_q  <= cfg_wdata;
				plmw_pkg::REG_MAX_SCORE:     maxs_q   <= cfg_wdata;
				plmw_pkg::REG_MIN_PROB:      minp_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= 40'sd0;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready && state_q != ST_WOUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_SQX;
					end
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_DG;
				ST_DG:   state_q <= ST_LG0;
				ST_LG0:  state_q <= ST_LG1;
				ST_LG1:  state_q <= ST_EXPR;
				ST_EXPR: state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_COSM;
				ST_COSM: state_q <= ST_TERM;
				ST_TERM: state_q <= ST_ACC;
				ST_ACC: begin
					if (acc_w > 41'(plmw_pkg::SUM_LIMIT)) begin
						sum_q <= plmw_pkg::SUM_LIMIT;
					end else if (acc_w < -41'(plmw_pkg::SUM_LIMIT)) begin
						sum_q <= -plmw_pkg::SUM_LIMIT;
					end else begin
						sum_q <= acc_w[39:0];
					end
					state_q <= last_q ? ST_LOGN : ST_IDLE;
				end
				ST_LOGN: begin
					cnt_q   <= 5'd0;
					state_q <= ST_LOGSQ;
				end
				ST_LOGSQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					cnt_q   <= 5'd20;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_WEXP;
					end
				end
				ST_WEXP: state_q <= ST_WOUT;
				ST_WOUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						sum_q       <= 40'sd0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ox_q   <= $signed(s_axis_tdata[12:0]);
				oy_q   <= $signed(s_axis_tdata[25:13]);
				hd_q   <= s_axis_tdata[34:26];
				cost_q <= s_axis_tdata[42:35];
				ang_q  <= s_axis_tdata[50:43];
				last_q <= s_axis_tlast;
			end
			ST_SQX:  d2_q <= mul_p[25:0];
			ST_SQY:  d2_q <= d2_q + mul_p[25:0];
			ST_DG:   p1_q <= mul_p[41:0];
			ST_LG0:  p2_q <= mul_p[41:0];
			ST_LG1:  t_q  <= t_full[62 -: T_W];
			ST_GAIN: gain_q <= exp2_eval(rom_q, t_q[T_W-1:16]);
			ST_COSM: begin
				inner_q <= $signed({2'd0, mul_p[24:0]})
					+ $signed({{2{offset_q[8]}}, offset_q, 16'd0});
			end
			ST_TERM: term_q <= tsum[42:24];
			ST_LOGN: begin
				m_q <= m_w;
				if (sum_ext > m_ext) begin
					s_q     <= $signed({1'b0, m_w});
					clamp_q <= 1'b1;
				end else if (sum_ext < -m_ext) begin
					s_q     <= -$signed({1'b0, m_w});
					clamp_q <= 1'b1;
				end else begin
					s_q     <= sum_q[24:0];
					clamp_q <= 1'b0;
				end
				y_q    <= 32'(p_eff) << (5'd30 - {1'b0, p_msb});
				lres_q <= {p_msb, 16'd0};
			end
			ST_LOGSQ: begin
				if (ysq[31]) begin
					y_q <= ysq >> 1;
					lres_q[4'd15 - cnt_q[3:0]] <= 1'b1;
				end else begin
					y_q <= ysq;
				end
			end
			ST_LMUL: begin
				rem_q  <= mul_p[46:0] + {23'd0, m_q};
				dsh_q  <= {m_q, 1'b0, 20'd0};
				quot_q <= 21'd0;
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - {2'd0, dsh_q};
				end
				dsh_q  <= dsh_q >> 1;
				quot_q <= quot_next;
				if (cnt_q == 5'd0) begin
					t_q <= T_W'(quot_next);
				end
			end
			ST_WOUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_w_q <= exp2_eval(rom_q, t_q[T_W-1:16]);
					out_s_q <= rnd_s[24:8];
					out_c_q <= clamp_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_s_q, out_w_q};
	assign m_axis_tuser  = out_c_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [plmw_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [plmw_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic m_axis_tuser;

	particle_line_match_weight_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	typedef struct packed {
		logic [16:0] weight;
		logic [16:0] score;
		logic        clamped;
	} weight_t;

	typedef struct {
		logic signed [12:0] ox;
		logic signed [12:0] oy;
		logic [8:0]         hdg;
		logic [7:0]         cost;
		logic [7:0]         ang;
		logic               last;
		logic               has_exp;
		weight_t            exp_w;
	} sample_t;

	logic [31:0] exp2_rom [plmw_pkg::EXP_TABLE_DEPTH];
	logic [16:0] cos_rom [plmw_pkg::COS_DEPTH];

	logic signed [63:0] m_offset;
	logic [63:0] m_gain, m_max, m_minp;
	logic signed [63:0] m_sum;

	weight_t weight_q[$];
	int errors = 0;
	int mismatches = 0;
	int table_errors = 0;
	int cycles = 0;
	int send_idle, recv_stall;
	bit draining;
	localparam int CYCLE_LIMIT = 2000000;

	function automatic logic [31:0] series_exp2(logic [63:0] y);
		logic signed [63:0] sum;
		logic [63:0] term;
		logic [63:0] res;
		sum = 64'sd1 <<< 32;
		term = 64'd1 << 32;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * y) >> 32) / 64'(k);
			if (k % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		res = ($unsigned(sum) + 64'd2) >> 2;
		return res[31:0];
	endfunction

	function automatic logic [16:0] series_cos(int i);
		logic [63:0] x, x2, term, res;
		logic signed [63:0] sum;
		x = 64'(i) * plmw_pkg::DEG_Q30;
		x2 = (x * x) >> 30;
		sum = 64'sd1 <<< 30;
		term = 64'd1 << 30;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		if (sum < 0) sum = 0;
		res = ($unsigned(sum) + 64'd8192) >> 14;
		return res[16:0];
	endfunction

	function automatic logic [63:0] pow2_neg(logic [63:0] t);
		logic [63:0] n, idx;
		n = t >> 16;
		idx = ((t & 64'hFFFF) * plmw_pkg::EXP_TABLE_DEPTH) >> 16;
		if (n >= plmw_pkg::EXP_SHIFT_LIMIT) return 0;
		return (64'(exp2_rom[idx]) + (64'd1 << (13 + n))) >> (14 + n);
	endfunction

	function automatic logic [63:0] log2_fix(logic [63:0] v);
		int n;
		logic [63:0] y, res;
		n = 0;
		while ((v >> (n + 1)) != 0) n++;
		res = 64'(n) << 16;
		y = v << (30 - n);
		for (int b = 0; b < 16; b++) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				res[15 - b] = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic bit accumulate_sample(sample_t s, output weight_t w);
		logic signed [63:0] ox, oy, inner, prod, term, m, sc, r;
		logic [63:0] d2, t, gain, hd, d, p, lq;
		ox = 64'(s.ox);
		oy = 64'(s.oy);
		d2 = ox * ox + oy * oy;
		t = (m_gain * d2 * 64'(plmw_pkg::LOG2E_Q20))
			>> (20 + 2 * plmw_pkg::POSITION_FRAC_BITS);
		gain = pow2_neg(t);
		hd = 64'(s.hdg) % 360;
		d = (hd + 360 - 64'(s.ang)) % 360;
		if (d > 180) d = 360 - d;
		if (d > 90) d = 180 - d;
		inner = $signed(64'(s.cost) * 64'(cos_rom[d])) + m_offset * 65536;
		prod = inner * $signed(gain);
		term = $signed((prod + (64'sd1 <<< 42) + (64'sd1 <<< 23)) >>> 24) - (64'sd1 <<< 18);
		m_sum = m_sum + term;
		if (m_sum > 64'(plmw_pkg::SUM_LIMIT)) m_sum = 64'(plmw_pkg::SUM_LIMIT);
		if (m_sum < -64'(plmw_pkg::SUM_LIMIT)) m_sum = -64'(plmw_pkg::SUM_LIMIT);
		if (!s.last) return 0;
		m = $signed((m_max != 0 ? m_max : 64'd1) * 256);
		sc = m_sum;
		w.clamped = (sc > m) || (sc < -m);
		if (sc > m) sc = m;
		if (sc < -m) sc = -m;
		p = m_minp != 0 ? m_minp : 64'd1;
		lq = (64'd16 << 16) - log2_fix(p);
		t = (lq * $unsigned(m - sc) + $unsigned(m)) / $unsigned(2 * m);
		w.weight = 17'(pow2_neg(t));
		r = $signed((sc + (64'sd1 <<< 32) + 128) >>> 8) - (64'sd1 <<< 24);
		w.score = r[16:0];
		m_sum = 0;
		return 1;
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		weight_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tuser};
			if (weight_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result %p", got);
			end else begin
				want = weight_q.pop_front();
				if (got !== want) begin
					errors++;
					if (mismatches++ < 10) $display("mismatch exp %p got %p", want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (draining) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic write_reg(logic [plmw_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		while (!s_axis_tready) @(negedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			plmw_pkg::REG_SCORE_OFFSET: m_offset = $signed(val[8:0]);
			plmw_pkg::REG_DISTANCE_GAIN: m_gain = val;
			plmw_pkg::REG_MAX_SCORE: m_max = val;
			default: m_minp = val;
		endcase
	endtask

	task automatic send_sample(sample_t s);
		weight_t w;
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, s.ang, s.cost, s.hdg, s.oy, s.ox};
		s_axis_tlast <= s.last;
		do @(posedge clk); while (!s_axis_tready);
		if (accumulate_sample(s, w)) begin
			if (s.has_exp && w !== s.exp_w) begin
				table_errors++;
				$display("predictor disagrees with table %p %p", s.exp_w, w);
			end
			weight_q.insert(weight_q.size(), w);
		end
		@(negedge clk);
	endtask

	task automatic settle;
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (weight_q.size() != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		repeat (100) @(negedge clk);
	endtask

	function automatic sample_t rand_sample(bit last);
		sample_t s;
		int r;
		r = $urandom_range(9);
		s.ox = r < 7 ? 13'($signed($urandom_range(64)) - 32) : 13'($urandom);
		s.oy = r < 7 ? 13'($signed($urandom_range(64)) - 32) : 13'($urandom);
		s.hdg = $urandom_range(9) == 0 ? 9'($urandom) : 9'($urandom_range(359));
		s.cost = 8'($urandom);
		s.ang = 8'($urandom);
		s.last = last;
		s.has_exp = 0;
		return s;
	endfunction

	sample_t directed[$];

	function automatic sample_t mk(int ox, int oy, int hd, int c, int a, bit l,
			bit he = 0, weight_t w = '0);
		sample_t s;
		s.ox = 13'(ox); s.oy = 13'(oy); s.hdg = 9'(hd); s.cost = 8'(c); s.ang = 8'(a);
		s.last = l;
		s.has_exp = he; s.exp_w = w;
		return s;
	endfunction

	initial begin
		int len;
		logic [15:0] cfg_sets [4][4];
		for (int i = 0; i < plmw_pkg::EXP_TABLE_DEPTH; i++)
			exp2_rom[i] = series_exp2((64'(i) * plmw_pkg::LN2_Q32)
				/ plmw_pkg::EXP_TABLE_DEPTH);
		for (int i = 0; i < plmw_pkg::COS_DEPTH; i++) cos_rom[i] = series_cos(i);
		draining = 0;
		send_idle = 0; recv_stall = 0;
		cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
		s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tlast = 0;
		m_offset = -64; m_gain = 66; m_max = 5000; m_minp = 655; m_sum = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// score zero at reset settings gives sqrt of min probability
		directed = {directed, mk(0, 0, 90, 64, 90, 1, 1,
			{17'(pow2_neg(((64'd16 << 16) - log2_fix(655) + 1) / 2)), 17'd0, 1'b0})};
		directed = {directed, mk(4095, -4096, 359, 255, 255, 1)};
		directed = {directed, mk(-4096, 4095, 0, 255, 0, 0)};
		directed = {directed, mk(0, 0, 0, 255, 0, 1)};
		directed = {directed, mk(0, 0, 511, 255, 151, 1)};
		directed = {directed, mk(0, 0, 360, 0, 180, 1)};
		directed = {directed, mk(3, -5, 45, 128, 200, 0)};
		directed = {directed, mk(-7, 2, 270, 255, 90, 1)};
		for (int i = 0; i < directed.size(); i++) send_sample(directed[i]);
		settle();

		write_reg(plmw_pkg::REG_SCORE_OFFSET, 16'h00FF);
		write_reg(plmw_pkg::REG_DISTANCE_GAIN, 16'd0);
		write_reg(plmw_pkg::REG_MAX_SCORE, 16'd1);
		write_reg(plmw_pkg::REG_MIN_PROB, 16'd1);
		send_sample(mk(0, 0, 0, 255, 0, 1));
		write_reg(plmw_pkg::REG_MAX_SCORE, 16'd0);
		write_reg(plmw_pkg::REG_MIN_PROB, 16'd0);
		send_sample(mk(0, 0, 0, 0, 0, 1));
		write_reg(plmw_pkg::REG_SCORE_OFFSET, 16'h0101);
		write_reg(plmw_pkg::REG_MAX_SCORE, 16'hFFFF);
		write_reg(plmw_pkg::REG_MIN_PROB, 16'hFFFF);
		for (int i = 0; i < 12; i++) send_sample(mk(0, 0, 0, 0, 0, i == 11));
		settle();

		cfg_sets[0] = '{16'hFFC0, 16'd66, 16'd5000, 16'd655};
		cfg_sets[1] = '{16'h00FF, 16'hFFFF, 16'd200, 16'd1};
		cfg_sets[2] = '{16'h0101, 16'd0, 16'hFFFF, 16'hFFFF};
		cfg_sets[3] = '{16'h0010, 16'd3000, 16'd40, 16'd30000};
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 77; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 77; end
				default: begin send_idle = 24; recv_stall = 24; end
			endcase
			write_reg(plmw_pkg::REG_SCORE_OFFSET, cfg_sets[ph][0]);
			write_reg(plmw_pkg::REG_DISTANCE_GAIN, cfg_sets[ph][1]);
			write_reg(plmw_pkg::REG_MAX_SCORE, cfg_sets[ph][2]);
			write_reg(plmw_pkg::REG_MIN_PROB, cfg_sets[ph][3]);
			for (int n = 0; n < 385;) begin
				len = $urandom_range(3) == 0 ? 1 : $urandom_range(12, 1);
				for (int j = 0; j < len; j++) begin
					send_sample(rand_sample(j == len - 1));
					n++;
				end
			end
			settle();
		end

		draining = 1;
		settle();
		if (errors == 0 && table_errors == 0 && weight_q.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule

FILE: particle_line_match_weight_top.f
rtl/plmw_pkg.sv
rtl/particle_line_match_weight_top.sv
verif/tb.sv
